>>> rtl/core/bsfd_pkg.sv
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants of the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
package bsfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ADDR_W = 3;

  // packed result fields plus zero fill to whole bytes
  localparam int unsigned RES_BITS   = BYTE_W + POS_W + LEN_W;
  localparam int unsigned OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_START_BYTE  = 3'd0,
    REG_END_BYTE    = 3'd1,
    REG_ESCAPE_BYTE = 3'd2,
    REG_ESCAPE_MASK = 3'd3,
    REG_MAX_LENGTH  = 3'd4
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd192;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd193;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] ESCAPE_MASK_RST = 8'd32;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 13'd4096;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_xor_mask;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

endpackage

>>> rtl/core/bsfd_cfg.sv
// ----------------------------------------------------------------------------
// bsfd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bsfd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bsfd_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [bsfd_pkg::LEN_W-1:0]  cfg_wdata,
  output bsfd_pkg::cfg_t              cfg
);
  import bsfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_START_BYTE:  cfg_nxt.start_byte      = cfg_wdata[BYTE_W-1:0];
        REG_END_BYTE:    cfg_nxt.end_byte        = cfg_wdata[BYTE_W-1:0];
        REG_ESCAPE_BYTE: cfg_nxt.escape_byte     = cfg_wdata[BYTE_W-1:0];
        REG_ESCAPE_MASK: cfg_nxt.escape_xor_mask = cfg_wdata[BYTE_W-1:0];
        REG_MAX_LENGTH:  cfg_nxt.max_length      = cfg_wdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte      <= START_BYTE_RST;
      cfg_r.end_byte        <= END_BYTE_RST;
      cfg_r.escape_byte     <= ESCAPE_BYTE_RST;
      cfg_r.escape_xor_mask <= ESCAPE_MASK_RST;
      cfg_r.max_length      <= MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/bsfd_core.sv
// ----------------------------------------------------------------------------
// bsfd_core
// Frame state (in-frame, escape, byte count) and the per-byte decode.
// ----------------------------------------------------------------------------
module bsfd_core #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsfd_pkg::cfg_t              cfg,
  input  logic                        item_valid,
  input  logic                        item_fire,
  input  logic [bsfd_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        timed_out,
  output logic                        res_valid,
  output bsfd_pkg::res_t              res
);
  import bsfd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CMP_W-1:0] FRAME_CAP = CMP_W'(MAX_FRAME);

  logic             in_frame_r, in_frame_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [CMP_W-1:0]  count_ext;
  logic [CMP_W-1:0]  max_ext;
  logic [CMP_W-1:0]  limit;
  logic [BYTE_W-1:0] data_byte;

  assign count_ext = CMP_W'(count_r);
  assign max_ext   = CMP_W'(cfg.max_length);
  assign limit     = (max_ext > FRAME_CAP) ? FRAME_CAP : max_ext;
  assign data_byte = esc_r ? (rx_byte ^ cfg.escape_xor_mask) : rx_byte;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    count_nxt    = count_r;
    res_valid    = 1'b0;
    res          = '0;
    res.kind     = KIND_DATA;
    priority if (timed_out) begin
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      count_nxt    = '0;
      res_valid    = 1'b1;
      res.kind     = KIND_TIMEOUT;
    end else if (rx_byte == cfg.start_byte) begin
      in_frame_nxt = 1'b1;
      esc_nxt      = 1'b0;
      count_nxt    = '0;
    end else if (rx_byte == cfg.end_byte) begin
      in_frame_nxt     = 1'b0;
      esc_nxt          = 1'b0;
      count_nxt        = '0;
      // empty frame closes silently
      res_valid        = (count_r != '0);
      res.kind         = KIND_END;
      res.frame_length = count_ext[LEN_W-1:0];
    end else if (rx_byte == cfg.escape_byte) begin
      esc_nxt = 1'b1;
    end else if (in_frame_r) begin
      esc_nxt   = 1'b0;
      res_valid = 1'b1;
      if (count_ext < limit) begin
        count_nxt    = count_r + CNT_W'(1);
        res.kind     = KIND_DATA;
        res.out_byte = data_byte;
        res.position = count_ext[POS_W-1:0];
      end else begin
        // buffer full: byte dropped, frame closed at its current length
        in_frame_nxt     = 1'b0;
        count_nxt        = '0;
        res.kind         = KIND_FULL;
        res.frame_length = count_ext[LEN_W-1:0];
      end
    end else begin
      // data outside a frame is dropped, an armed escape stays
      res_valid = 1'b0;
    end
    if (!item_valid) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      count_r    <= '0;
    end else if (item_fire) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

>>> rtl/core/byte_stuffed_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_top
// Byte-stuffed frame decoder: un-escapes received bytes and reports frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per received byte (in_tdata) or timeout event (in_tuser).
//   out_* : at most one result beat per input beat; kind in out_tuser, data
//           byte, position and frame length packed in out_tdata.
//   cfg_* : register writes; the user must write only while no beat is in flight, unchecked.
// Path: an input beat is taken into the input register, then decoded into
//   the output register that drives out_tvalid.
// Throughput: one beat per cycle outside a stall; the decode is one compare
//   chain plus the byte-count add and limit compare between the registers.
// Start and escape bytes, bytes outside a frame and the end of an empty frame
//   give no result beat; their input beat moves on even past a held result.
// Reset: synchronous on rst_n; both pipeline registers empty, frame state
//   cleared, configuration registers back to their defaults.
// Stall: while out_tready is low a waiting result holds; the input register
//   still drains beats that give no result, and in_tready drops only when a
//   result-producing beat is blocked behind the held one.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_top #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                      in_tuser,   // [0] timed_out
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_byte, [19:8] position, [32:20] frame_length, rest zero
  output logic [bsfd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,  // [1:0] kind
  // configuration
  input  logic                            cfg_we,
  input  logic [bsfd_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [bsfd_pkg::LEN_W-1:0]      cfg_wdata
);
  import bsfd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;

  logic              s1_v_r, s1_v_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_to_r;
  logic              o_v_r, o_v_nxt;
  res_t              o_res_r;

  logic in_fire;
  logic s1_go;

  bsfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsfd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_v_r),
    .item_fire  (s1_go),
    .rx_byte    (s1_byte_r),
    .timed_out  (s1_to_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // a held item moves on if it gives no result or the output slot frees up
  assign s1_go     = s1_v_r && (!res_valid || !o_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    o_v_nxt = o_v_r;
    if (s1_go && res_valid) begin
      o_v_nxt = 1'b1;
    end else if (out_tready) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_to_r   <= in_tuser[0];
    end
    if (s1_go && res_valid) begin
      o_res_r <= res;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_res_r.kind;
  assign out_tdata  = OUT_DATA_W'({o_res_r.frame_length, o_res_r.position, o_res_r.out_byte});

endmodule

>>> rtl/core/bsfd_checker.sv
// ----------------------------------------------------------------------------
// bsfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bsfd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bsfd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);
  import bsfd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // nothing on the result side right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // data beats carry no frame length
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |-> out_tdata[32:20] == '0)
    else $error("data beat with nonzero length");

  // a normal end reports a non-empty frame
  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tdata[32:20] != '0 && out_tdata[19:0] == '0)
    else $error("end beat with empty length or stray fields");

  // timeout beats are all zero
  a_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TIMEOUT |-> out_tdata == '0)
    else $error("timeout beat with nonzero payload");

endmodule

bind byte_stuffed_frame_decoder_top bsfd_checker u_bsfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/byte_stuffed_frame_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_top_tb
// Self-checking bench for the byte-stuffed frame decoder. A clocked driver
// feeds received bytes and timeout events from a queue, and a predictor
// decodes every accepted beat into the expected result. A clocked monitor
// compares each result beat field by field with the oldest expectation.
// Several marker, mask and buffer-size settings are run, including equal
// markers, a zero-size buffer and one frame that fills the whole buffer.
// Both sides idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bsfd_pkg::*;

  localparam int FRAME_CAP   = 4096;
  localparam int IDLE_PCT    = 18;
  localparam int QUIET_LIMIT = 3000;
  localparam int STALL_LEN   = 400;
  localparam int FILL_LEN    = 150;

  typedef struct packed {
    logic             tmo;
    logic [BYTE_W-1:0] data;
  } rx_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [7:0] rx_byte
  logic [0:0]             in_tuser = '0;   // [0] timed_out
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] out_byte, [19:8] position, [32:20] frame_length, rest zero
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [1:0]             out_tuser;       // [1:0] kind
  logic                   cfg_we = 1'b0;
  logic [ADDR_W-1:0]      cfg_addr = '0;
  logic [LEN_W-1:0]       cfg_wdata = '0;

  byte_stuffed_frame_decoder_top #(
    .MAX_FRAME(FRAME_CAP)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // decoder copy: configuration and frame state
  cfg_t              dec_cfg = '{START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST,
                                 ESCAPE_MASK_RST, MAX_LENGTH_RST};
  logic              dec_in_frame = 1'b0;
  logic              dec_escape = 1'b0;
  logic [LEN_W-1:0]  dec_count = '0;

  rx_item_t          rx_pending[$];
  res_t              expected_results[$];
  rx_item_t          offered;
  res_t              predicted;
  res_t              got;
  int                pushed_total = 0;
  int                error_cnt = 0;
  int                cycle_cnt = 0;
  int                quiet_cycles = 0;
  int                hold_left = 0;
  logic              stall_phase = 1'b0;
  logic              stall_done = 1'b0;
  logic              calm;

  // a quiet window with no idling on either side
  assign calm = (cycle_cnt % 1500) >= 1100;

  function automatic bit decode_step(input rx_item_t it, output res_t r);
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  lim;
    logic [LEN_W-1:0]  len;
    b = it.data;
    r = '0;
    if (it.tmo) begin
      dec_in_frame = 1'b0;
      dec_escape = 1'b0;
      dec_count = '0;
      r.kind = KIND_TIMEOUT;
      return 1'b1;
    end
    if (b == dec_cfg.start_byte) begin
      dec_count = '0;
      dec_in_frame = 1'b1;
      dec_escape = 1'b0;
      return 1'b0;
    end
    if (b == dec_cfg.end_byte) begin
      len = dec_count;
      dec_in_frame = 1'b0;
      dec_escape = 1'b0;
      dec_count = '0;
      r.kind = KIND_END;
      r.frame_length = len;
      return len != 0;
    end
    if (b == dec_cfg.escape_byte) begin
      dec_escape = 1'b1;
      return 1'b0;
    end
    // data byte
    if (!dec_in_frame) return 1'b0;
    if (dec_escape) begin
      b = b ^ dec_cfg.escape_xor_mask;
      dec_escape = 1'b0;
    end
    lim = (dec_cfg.max_length > FRAME_CAP) ? LEN_W'(FRAME_CAP) : dec_cfg.max_length;
    if (dec_count < lim) begin
      r.kind = KIND_DATA;
      r.out_byte = b;
      r.position = dec_count[POS_W-1:0];
      dec_count = dec_count + 1'b1;
    end else begin
      r.kind = KIND_FULL;
      r.frame_length = dec_count;
      dec_in_frame = 1'b0;
      dec_escape = 1'b0;
      dec_count = '0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_marker(input logic [BYTE_W-1:0] b);
    return b == dec_cfg.start_byte || b == dec_cfg.end_byte || b == dec_cfg.escape_byte;
  endfunction

  task automatic push_rx(input logic [BYTE_W-1:0] v);
    rx_pending.push_back('{tmo: 1'b0, data: v});
    pushed_total++;
  endtask

  task automatic push_timeout(input logic [BYTE_W-1:0] v);
    rx_pending.push_back('{tmo: 1'b1, data: v});
    pushed_total++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_START_BYTE:  dec_cfg.start_byte = v[BYTE_W-1:0];
      REG_END_BYTE:    dec_cfg.end_byte = v[BYTE_W-1:0];
      REG_ESCAPE_BYTE: dec_cfg.escape_byte = v[BYTE_W-1:0];
      REG_ESCAPE_MASK: dec_cfg.escape_xor_mask = v[BYTE_W-1:0];
      REG_MAX_LENGTH:  dec_cfg.max_length = v;
      default: ;
    endcase
  endtask

  task automatic program_decoder(input logic [7:0] sop, input logic [7:0] eop,
                                 input logic [7:0] esc, input logic [7:0] mask,
                                 input logic [LEN_W-1:0] max_len);
    write_reg(REG_START_BYTE, LEN_W'(sop));
    write_reg(REG_END_BYTE, LEN_W'(eop));
    write_reg(REG_ESCAPE_BYTE, LEN_W'(esc));
    write_reg(REG_ESCAPE_MASK, LEN_W'(mask));
    write_reg(REG_MAX_LENGTH, max_len);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every beat is taken and every result has come out
  task automatic settle();
    while (rx_pending.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // mostly well-formed stuffed frames, some noise and broken frames
  task automatic add_traffic(input int n);
    int target;
    int lim;
    int span;
    int len;
    int pick;
    logic [BYTE_W-1:0] d;
    target = pushed_total + n;
    lim = (dec_cfg.max_length > FRAME_CAP) ? FRAME_CAP : int'(dec_cfg.max_length);
    while (pushed_total < target) begin
      if ($urandom_range(99) < 85) begin
        push_rx(dec_cfg.start_byte);
        span = (lim + 2 > 12) ? 12 : lim + 2;
        if ($urandom_range(9) == 0) span = (lim + 2 > 60) ? 60 : lim + 2;
        len = $urandom_range(span);
        repeat (len) begin
          d = BYTE_W'($urandom_range(255));
          if (is_marker(d)) begin
            push_rx(dec_cfg.escape_byte);
            push_rx(d ^ dec_cfg.escape_xor_mask);
          end else if ($urandom_range(9) == 0) begin
            push_rx(dec_cfg.escape_byte);
            push_rx(d);
          end else begin
            push_rx(d);
          end
        end
        pick = $urandom_range(19);
        if (pick < 17) push_rx(dec_cfg.end_byte);
        else if (pick < 19) push_timeout(BYTE_W'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(4))
            0: push_rx(BYTE_W'($urandom_range(255)));
            1: push_timeout(BYTE_W'($urandom_range(255)));
            2: push_rx(dec_cfg.escape_byte);
            3: push_rx(dec_cfg.end_byte);
            default: push_rx(dec_cfg.start_byte);
          endcase
        end
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int seen);
    if (want != seen) begin
      error_cnt++;
      if (error_cnt <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (decode_step(offered, predicted)) expected_results.push_back(predicted);
      end
      if (!in_tvalid || in_tready) begin
        if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          offered = rx_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= offered.data;
          in_tuser <= offered.tmo;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 100)
            $display("%0t: result beat with nothing expected, expected none, actual %h/%h",
                     $time, out_tuser, out_tdata);
        end else begin
          got = expected_results.pop_front();
          check_field("kind", int'(got.kind), int'(out_tuser));
          check_field("out_byte", int'(got.out_byte), int'(out_tdata[7:0]));
          check_field("position", int'(got.position), int'(out_tdata[19:8]));
          check_field("frame_length", int'(got.frame_length), int'(out_tdata[32:20]));
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else if (stall_phase && !stall_done) begin
        // long hold-off so the decoder backs up into its input
        hold_left = STALL_LEN;
        stall_done = 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("byte_stuffed_frame_decoder_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [BYTE_W-1:0] d;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default markers: edge cases first
    push_rx(8'h00);                  // data outside a frame
    push_rx(ESCAPE_BYTE_RST);        // escape outside a frame
    push_rx(8'h41);                  // dropped, escape stays armed
    push_rx(END_BYTE_RST);           // end on unopened frame
    push_rx(START_BYTE_RST);
    push_rx(END_BYTE_RST);           // empty frame
    push_rx(START_BYTE_RST);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(ESCAPE_BYTE_RST);
    push_rx(8'h5D);
    push_rx(ESCAPE_BYTE_RST);
    push_rx(ESCAPE_BYTE_RST);        // escape twice stays armed once
    push_rx(8'hE0);
    push_rx(END_BYTE_RST);
    push_rx(START_BYTE_RST);
    push_rx(8'h12);
    push_timeout(END_BYTE_RST);      // abort inside a frame, byte ignored
    push_timeout(8'hFF);             // timeout outside a frame
    push_rx(START_BYTE_RST);
    push_rx(8'h34);
    push_rx(START_BYTE_RST);         // restart drops the count
    push_rx(8'h56);
    push_rx(END_BYTE_RST);
    push_rx(ESCAPE_BYTE_RST);
    push_rx(START_BYTE_RST);         // start clears a pending escape
    push_rx(8'h5D);
    push_rx(END_BYTE_RST);
    settle();

    // start and end markers on one value: start wins over end, one-byte buffer
    program_decoder(8'h00, 8'h00, 8'hFF, 8'hFF, 13'd1);
    add_traffic(60);
    settle();

    // end wins over escape, zero mask
    program_decoder(8'hAA, 8'h55, 8'h55, 8'h00, 13'd3);
    add_traffic(60);
    settle();

    // receiver holds off while the sender keeps offering
    stall_phase = 1'b1;
    program_decoder(START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST, 13'd200);
    add_traffic(100);
    settle();
    stall_phase = 1'b0;

    // one frame runs to the end of the buffer
    program_decoder(8'h7E, 8'h7F, 8'h7D, 8'h20, LEN_W'(FILL_LEN));
    push_rx(8'h7E);
    repeat (FILL_LEN + 1) begin
      do d = BYTE_W'($urandom_range(255)); while (is_marker(d));
      push_rx(d);
    end
    add_traffic(60);
    settle();

    // zero-size buffer: every data byte in a frame ends it
    program_decoder(8'hC0, 8'hC1, 8'hDB, 8'hFF, 13'd0);
    add_traffic(30);
    settle();

    // size above the cap is clipped
    program_decoder(8'h10, 8'h20, 8'h30, 8'h5A, 13'd8191);
    add_traffic(60);
    settle();

    repeat (4) @(negedge clk);
    if (error_cnt == 0 && expected_results.size() == 0) begin
      $display("byte_stuffed_frame_decoder_top verification clean");
    end else begin
      $display("byte_stuffed_frame_decoder_top verification failed");
    end
    $finish;
  end

endmodule
